[hw/rtl/process_id_slot_allocator_assert.svh]
// Assertion macros for the process ID slot allocator.
`ifndef PROCESS_ID_SLOT_ALLOCATOR_ASSERT_SVH
`define PROCESS_ID_SLOT_ALLOCATOR_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define PISA_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("process_id_slot_allocator: assertion failed");

// Next-cycle implication, sampled on clk, off during reset.
`define PISA_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("process_id_slot_allocator: assertion failed");

`endif

[hw/rtl/pisa_pkg.sv]
// Shared constants, codes and controller/datapath interface types.
package pisa_pkg;

  localparam int SLOTS = 64;
  localparam int IDX_W = $clog2(SLOTS);
  localparam int ID_W = 16;
  localparam int HANDLE_W = 16;
  localparam int MODE_W = 2;
  localparam int STATUS_W = 2;

  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(SLOTS - 1);
  localparam logic [ID_W-1:0] FIRST_PID = ID_W'(2);

  localparam logic [MODE_W-1:0] MODE_ASSIGN = 2'd0;
  localparam logic [MODE_W-1:0] MODE_RELEASE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_LOOKUP = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;

  typedef struct packed {
    logic start;
    logic scan;
    logic commit;
  } pisa_cmd_t;

  typedef struct packed {
    logic scan_end;
  } pisa_stat_t;

endpackage

[hw/rtl/process_id_slot_allocator.sv]
// Process ID slot allocator: SLOTS-entry table that hands out rising IDs, releases
// them and looks up their owner handles. One request is handled at a time: after a
// transaction is accepted the table is scanned one slot per cycle through its single
// memory read port, stopping at the first free slot (assign) or the first valid slot
// holding the ID (release, lookup). Once the scan ends, the result is committed to the result
// register as soon as the previous result has been taken, and only then is the next request
// accepted. Every request yields one result.
module process_id_slot_allocator
  import pisa_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [MODE_W-1:0]   in_mode,
  input  logic [HANDLE_W-1:0] in_owner_handle,
  input  logic [ID_W-1:0]     in_id_in,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [ID_W-1:0]     out_id_out,
  output logic [HANDLE_W-1:0] out_handle_out,
  output logic [STATUS_W-1:0] out_status
);

  pisa_cmd_t  cmd;
  pisa_stat_t stat;

  pisa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  pisa_dpath u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .in_mode         (in_mode),
    .in_owner_handle (in_owner_handle),
    .in_id_in        (in_id_in),
    .out_id_out      (out_id_out),
    .out_handle_out  (out_handle_out),
    .out_status      (out_status)
  );

`include "process_id_slot_allocator_assert.svh"

  `PISA_ASSERT_NXT(a_busy_after_accept, in_valid && in_ready, !in_ready)
  `PISA_ASSERT_NXT(a_commit_shows_result, cmd.commit, out_valid)
  `PISA_ASSERT_IMP(a_scan_only_when_busy, cmd.scan, !in_ready)

endmodule

[hw/rtl/pisa_ctrl.sv]
// Controller: sequences accept, table scan, commit and result handoff.
module pisa_ctrl
  import pisa_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  input  pisa_stat_t stat,
  output pisa_cmd_t  cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FIN
  } state_t;

  state_t state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;
  logic out_free;

  assign out_free = !out_valid_r || out_ready;
  assign in_ready = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    out_valid_nxt = out_valid_r;
    cmd = '0;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.start = 1'b1;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (stat.scan_end) begin
          state_nxt = S_FIN;
        end else begin
          cmd.scan = 1'b1;
        end
      end
      S_FIN: begin
        if (out_free) begin
          cmd.commit = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

[hw/rtl/pisa_dpath.sv]
// Datapath: slot table, valid bits, ID counter, scan pipeline and result register.
module pisa_dpath
  import pisa_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  pisa_cmd_t           cmd,
  output pisa_stat_t          stat,
  input  logic [MODE_W-1:0]   in_mode,
  input  logic [HANDLE_W-1:0] in_owner_handle,
  input  logic [ID_W-1:0]     in_id_in,
  output logic [ID_W-1:0]     out_id_out,
  output logic [HANDLE_W-1:0] out_handle_out,
  output logic [STATUS_W-1:0] out_status
);

  logic [HANDLE_W+ID_W-1:0] tbl_mem [SLOTS];
  logic [HANDLE_W+ID_W-1:0] rd_r;

  logic [SLOTS-1:0]    valid_r, valid_nxt;
  logic [ID_W-1:0]     next_id_r, next_id_nxt;
  logic [MODE_W-1:0]   mode_r;
  logic [HANDLE_W-1:0] handle_r;
  logic [ID_W-1:0]     id_r;

  logic [IDX_W-1:0] idx_r;
  logic             iss_done_r;
  logic             p_live_r;
  logic             p_v_r;
  logic             p_last_r;
  logic [IDX_W-1:0] p_idx_r;

  logic [ID_W-1:0]     out_id_r, out_id_nxt;
  logic [HANDLE_W-1:0] out_handle_r, out_handle_nxt;
  logic [STATUS_W-1:0] out_status_r, out_status_nxt;

  logic [ID_W-1:0]     rd_id;
  logic [HANDLE_W-1:0] rd_handle;
  logic                match;
  logic                hit;
  logic                wr_en;

  assign rd_id = rd_r[ID_W-1:0];
  assign rd_handle = rd_r[HANDLE_W+ID_W-1:ID_W];

  always_comb begin
    case (mode_r)
      MODE_ASSIGN: match = !p_v_r;
      MODE_RELEASE, MODE_LOOKUP: match = p_v_r && (rd_id == id_r);
      default: match = 1'b1;
    endcase
  end

  assign hit = p_live_r && match;
  assign stat.scan_end = p_live_r && (match || p_last_r);

  always_comb begin
    valid_nxt = valid_r;
    next_id_nxt = next_id_r;
    out_id_nxt = out_id_r;
    out_handle_nxt = out_handle_r;
    out_status_nxt = out_status_r;
    wr_en = 1'b0;
    if (cmd.commit) begin
      out_id_nxt = '0;
      out_handle_nxt = '0;
      out_status_nxt = ST_OK;
      case (mode_r)
        MODE_ASSIGN: begin
          if (hit && (next_id_r != '0)) begin
            wr_en = 1'b1;
            valid_nxt[p_idx_r] = 1'b1;
            out_id_nxt = next_id_r;
            next_id_nxt = next_id_r + ID_W'(1);
          end else begin
            out_status_nxt = ST_FULL;
          end
        end
        MODE_RELEASE: begin
          if (hit) begin
            valid_nxt[p_idx_r] = 1'b0;
          end else begin
            out_status_nxt = ST_NOT_FOUND;
          end
        end
        MODE_LOOKUP: begin
          if (hit) begin
            out_handle_nxt = rd_handle;
          end else begin
            out_status_nxt = ST_NOT_FOUND;
          end
        end
        default: begin
          out_status_nxt = ST_OK;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      tbl_mem[p_idx_r] <= {handle_r, next_id_r};
    end
    if (cmd.scan) begin
      rd_r <= tbl_mem[idx_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      next_id_r <= FIRST_PID;
      iss_done_r <= 1'b0;
      p_live_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      next_id_r <= next_id_nxt;
      if (cmd.start) begin
        iss_done_r <= 1'b0;
        p_live_r <= 1'b0;
      end else if (cmd.scan) begin
        p_live_r <= !iss_done_r;
        if (idx_r == IDX_LAST) begin
          iss_done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      mode_r <= in_mode;
      handle_r <= in_owner_handle;
      id_r <= in_id_in;
      idx_r <= '0;
    end else if (cmd.scan) begin
      p_idx_r <= idx_r;
      p_v_r <= valid_r[idx_r];
      p_last_r <= (idx_r == IDX_LAST);
      if (!iss_done_r && (idx_r != IDX_LAST)) begin
        idx_r <= idx_r + IDX_W'(1);
      end
    end
    out_id_r <= out_id_nxt;
    out_handle_r <= out_handle_nxt;
    out_status_r <= out_status_nxt;
  end

  assign out_id_out = out_id_r;
  assign out_handle_out = out_handle_r;
  assign out_status = out_status_r;

endmodule

[sim/testbench.sv]
// Testbench for process_id_slot_allocator: random and directed requests checked against a predictor.
module testbench;
  import pisa_pkg::*;

  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
  localparam int STALL_LIMIT = 5000;
  localparam int SHOW_LIMIT = 100;

  typedef enum logic [1:0] {ID_GIVEN, ID_LIVE, ID_NEWEST} id_src_t;

  typedef struct {
    logic [MODE_W-1:0]   mode;
    logic [HANDLE_W-1:0] handle;
    logic [ID_W-1:0]     id;
    id_src_t             src;
    logic                after_drain;
  } request_t;

  typedef struct packed {
    logic [ID_W-1:0]     id;
    logic [HANDLE_W-1:0] handle;
    logic [STATUS_W-1:0] status;
  } reply_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [MODE_W-1:0]   in_mode = MODE_ASSIGN;
  logic [HANDLE_W-1:0] in_owner_handle = '0;
  logic [ID_W-1:0]     in_id_in = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [ID_W-1:0]     out_id_out;
  logic [HANDLE_W-1:0] out_handle_out;
  logic [STATUS_W-1:0] out_status;

  logic                in_fire = 1'b0;
  int                  errors = 0;
  int                  issued = 0;
  request_t            request_q[$];
  reply_t              reply_q[$];

  logic                tbl_valid [SLOTS] = '{default: 1'b0};
  logic [HANDLE_W-1:0] tbl_handle [SLOTS] = '{default: '0};
  logic [ID_W-1:0]     tbl_id [SLOTS] = '{default: '0};
  logic [ID_W-1:0]     tbl_next_id = FIRST_PID;
  logic [ID_W-1:0]     tbl_newest = '0;

  process_id_slot_allocator uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_mode         (in_mode),
    .in_owner_handle (in_owner_handle),
    .in_id_in        (in_id_in),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_id_out      (out_id_out),
    .out_handle_out  (out_handle_out),
    .out_status      (out_status)
  );

  always #10 clk = ~clk;

  function automatic int find_owner_slot(logic [ID_W-1:0] id);
    int slot;
    slot = -1;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (tbl_valid[i] && tbl_id[i] == id) slot = i;
    end
    return slot;
  endfunction

  function automatic reply_t serve_request(logic [MODE_W-1:0] mode, logic [HANDLE_W-1:0] handle,
                                           logic [ID_W-1:0] id);
    reply_t r;
    int slot;
    r = '0;
    r.status = ST_OK;
    slot = -1;
    case (mode)
      MODE_ASSIGN: begin
        for (int i = SLOTS - 1; i >= 0; i--) begin
          if (!tbl_valid[i]) slot = i;
        end
        if (slot < 0 || tbl_next_id == '0) begin
          r.status = ST_FULL;
        end else begin
          tbl_valid[slot] = 1'b1;
          tbl_handle[slot] = handle;
          tbl_id[slot] = tbl_next_id;
          r.id = tbl_next_id;
          tbl_newest = tbl_next_id;
          tbl_next_id = tbl_next_id + ID_W'(1);
        end
      end
      MODE_RELEASE: begin
        slot = find_owner_slot(id);
        if (slot < 0) r.status = ST_NOT_FOUND;
        else tbl_valid[slot] = 1'b0;
      end
      MODE_LOOKUP: begin
        slot = find_owner_slot(id);
        if (slot < 0) r.status = ST_NOT_FOUND;
        else r.handle = tbl_handle[slot];
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  function automatic logic [ID_W-1:0] any_live_id(logic [ID_W-1:0] fallback);
    int live[$];
    for (int i = 0; i < SLOTS; i++) begin
      if (tbl_valid[i]) live.push_back(i);
    end
    if (live.size() == 0) return fallback;
    return tbl_id[live[$urandom_range(live.size() - 1)]];
  endfunction

  function automatic void check_field(string what, int unsigned want, int unsigned got);
    if (want !== got) begin
      errors++;
      if (errors <= SHOW_LIMIT)
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
    end
  endfunction

  task automatic queue_request(logic [MODE_W-1:0] mode, logic [HANDLE_W-1:0] handle,
                               logic [ID_W-1:0] id, id_src_t src, logic after_drain);
    request_t rq;
    rq.mode = mode;
    rq.handle = handle;
    rq.id = id;
    rq.src = src;
    rq.after_drain = after_drain;
    request_q.push_back(rq);
  endtask

  always @(negedge clk) begin : drive
    request_t nxt;
    logic go;
    logic quiet;
    go = 1'b0;
    quiet = issued >= 400 && issued < 700;
    if (rst_n && !(in_valid && !in_fire) && request_q.size() > 0) begin
      if (!(request_q[0].after_drain && reply_q.size() > 0) &&
          (quiet || $urandom_range(99) >= 6)) begin
        nxt = request_q.pop_front();
        case (nxt.src)
          ID_LIVE: nxt.id = any_live_id(nxt.id);
          ID_NEWEST: nxt.id = tbl_newest;
          default: begin
          end
        endcase
        issued++;
        go = 1'b1;
      end
    end
    if (!(in_valid && !in_fire)) begin
      in_valid <= go;
      if (go) begin
        in_mode <= nxt.mode;
        in_owner_handle <= nxt.handle;
        in_id_in <= nxt.id;
      end
    end
    out_ready <= quiet || ($urandom_range(99) >= 6);
  end

  always @(posedge clk) begin : sample
    reply_t want;
    int stall_cycles;
    if (!rst_n) begin
      in_fire <= 1'b0;
      stall_cycles = 0;
    end else begin
      in_fire <= in_valid && in_ready;
      if (in_valid && in_ready)
        reply_q.push_back(serve_request(in_mode, in_owner_handle, in_id_in));
      if (out_valid && out_ready) begin
        if (reply_q.size() == 0) begin
          errors++;
          if (errors <= SHOW_LIMIT)
            $display("%0t: unexpected transaction, expected none, %s %0h handle %0h status %0d",
                     $time, "actual id", out_id_out, out_handle_out, out_status);
        end else begin
          want = reply_q.pop_front();
          check_field("id_out", 32'(want.id), 32'(out_id_out));
          check_field("handle_out", 32'(want.handle), 32'(out_handle_out));
          check_field("status", 32'(want.status), 32'(out_status));
        end
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) stall_cycles = 0;
      else stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("process_id_slot_allocator regression: fail");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int seg;
    int roll;
    logic grow;
    // directed: empty table, extremes, zero handle, reuse of freed slot, unused mode
    queue_request(MODE_LOOKUP, 16'h1234, 16'h0000, ID_GIVEN, 1'b0);
    queue_request(MODE_RELEASE, 16'hffff, 16'hffff, ID_GIVEN, 1'b0);
    queue_request(MODE_UNUSED, 16'hffff, 16'hffff, ID_GIVEN, 1'b0);
    queue_request(MODE_ASSIGN, 16'hffff, 16'hffff, ID_GIVEN, 1'b0);
    queue_request(MODE_ASSIGN, 16'h0000, 16'h0000, ID_GIVEN, 1'b0);
    queue_request(MODE_ASSIGN, 16'h0001, 16'h5555, ID_GIVEN, 1'b0);
    queue_request(MODE_LOOKUP, 16'h0000, FIRST_PID, ID_GIVEN, 1'b0);
    queue_request(MODE_LOOKUP, 16'haaaa, FIRST_PID + ID_W'(1), ID_GIVEN, 1'b0);
    queue_request(MODE_LOOKUP, 16'h0000, FIRST_PID + ID_W'(2), ID_GIVEN, 1'b0);
    queue_request(MODE_LOOKUP, 16'h0000, 16'h0000, ID_GIVEN, 1'b0);
    queue_request(MODE_RELEASE, 16'h0000, FIRST_PID + ID_W'(1), ID_GIVEN, 1'b0);
    queue_request(MODE_LOOKUP, 16'h0000, FIRST_PID + ID_W'(1), ID_GIVEN, 1'b0);
    queue_request(MODE_RELEASE, 16'h0000, FIRST_PID + ID_W'(1), ID_GIVEN, 1'b0);
    queue_request(MODE_ASSIGN, 16'h8000, 16'h0000, ID_GIVEN, 1'b0);
    queue_request(MODE_UNUSED, 16'h0000, FIRST_PID, ID_GIVEN, 1'b0);
    queue_request(MODE_LOOKUP, 16'h0000, FIRST_PID, ID_GIVEN, 1'b0);
    queue_request(MODE_RELEASE, 16'h0000, FIRST_PID + ID_W'(3), ID_GIVEN, 1'b0);
    queue_request(MODE_LOOKUP, 16'h0000, FIRST_PID + ID_W'(3), ID_GIVEN, 1'b0);
    queue_request(MODE_LOOKUP, 16'h0000, 16'h8000, ID_GIVEN, 1'b0);

    // fill past capacity
    for (int k = 0; k < SLOTS + 6; k++)
      queue_request(MODE_ASSIGN, HANDLE_W'($urandom_range(65535, 1)), ID_W'($urandom),
                    ID_GIVEN, 1'b0);

    grow = 1'b0;
    while (request_q.size() < 1210) begin
      grow = !grow;
      seg = $urandom_range(90, 20);
      for (int k = 0; k < seg; k++) begin
        roll = $urandom_range(99);
        if (roll < 10)
          queue_request(MODE_W'($urandom_range(3)), HANDLE_W'($urandom),
                        (roll < 5) ? ID_W'($urandom) : ID_W'($urandom_range(800)),
                        ID_GIVEN, k == 0 && $urandom_range(3) == 0);
        else if (roll < (grow ? 70 : 20))
          queue_request(MODE_ASSIGN, HANDLE_W'($urandom_range(65535, 1)), ID_W'($urandom),
                        ID_GIVEN, k == 0 && $urandom_range(3) == 0);
        else if (roll < (grow ? 85 : 75))
          queue_request(MODE_RELEASE, HANDLE_W'($urandom), ID_W'($urandom), ID_LIVE,
                        k == 0 && $urandom_range(3) == 0);
        else
          queue_request(MODE_LOOKUP, HANDLE_W'($urandom), ID_W'($urandom), ID_LIVE,
                        k == 0 && $urandom_range(3) == 0);
      end
    end

    // empty the table, then cycle a single slot through assign, lookup and release
    queue_request(MODE_RELEASE, 16'h0000, 16'h0000, ID_LIVE, 1'b1);
    for (int k = 1; k < SLOTS; k++)
      queue_request(MODE_RELEASE, 16'h0000, 16'h0000, ID_LIVE, 1'b0);
    for (int p = 0; p < 8; p++) begin
      queue_request(MODE_ASSIGN, HANDLE_W'($urandom_range(65535, 1)), ID_W'($urandom),
                    ID_GIVEN, 1'b0);
      queue_request(MODE_LOOKUP, 16'h0000, 16'h0000, ID_NEWEST, 1'b0);
      queue_request(MODE_RELEASE, 16'h0000, 16'h0000, ID_NEWEST, 1'b0);
    end
    queue_request(MODE_ASSIGN, 16'h1111, 16'h0000, ID_GIVEN, 1'b1);
    queue_request(MODE_ASSIGN, 16'hffff, 16'hffff, ID_GIVEN, 1'b0);
    queue_request(MODE_LOOKUP, 16'h0000, 16'h0000, ID_GIVEN, 1'b0);
    queue_request(MODE_LOOKUP, 16'h0000, 16'hffff, ID_GIVEN, 1'b0);
    queue_request(MODE_RELEASE, 16'h0000, FIRST_PID, ID_GIVEN, 1'b0);
    queue_request(MODE_UNUSED, 16'h5a5a, 16'ha5a5, ID_GIVEN, 1'b0);
    queue_request(MODE_ASSIGN, 16'h0002, 16'h0000, ID_GIVEN, 1'b0);

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    while (request_q.size() > 0 || in_valid || reply_q.size() > 0) @(negedge clk);
    repeat (100) @(negedge clk);
    if (errors == 0) begin
      $display("process_id_slot_allocator regression: pass");
    end else begin
      $display("process_id_slot_allocator regression: fail");
    end
    $finish;
  end

endmodule
